// File: src/lpsa_pkg.sv
// Shared types, constants and functions of the log power spectrum averager.
// Depends on nothing; every other file imports it.
package lpsa_pkg;

  localparam int FRAME_POINTS_DEF  = 1024;
  localparam int AVERAGE_DEPTH_DEF = 10;

  localparam int IN_W       = 42;
  localparam int HALF_W     = IN_W / 2;
  localparam int PWR_W      = 2 * IN_W;
  localparam int DB_W       = 8;
  localparam int DB_CODES   = 1 << DB_W;
  localparam int POS_W      = 10;
  localparam int BIN_MAX_W  = 13;
  localparam int SLOT_MAX_W = 4;
  localparam int BIG_W      = 864;

  typedef struct packed {
    logic signed [IN_W-1:0]  re;
    logic signed [IN_W-1:0]  im;
    logic [BIN_MAX_W-1:0]    bin;
    logic [SLOT_MAX_W-1:0]   slot;
    logic [POS_W-1:0]        disp;
    logic                    last;
    logic                    had_prior;
    logic                    old_valid;
    logic [SLOT_MAX_W:0]     divisor;
  } job_t;

  // Magnitude of a two's complement value; the most negative value maps to 2^(IN_W-1).
  function automatic logic [IN_W-1:0] magnitude(input logic [IN_W-1:0] v);
    return v[IN_W-1] ? (~v + IN_W'(1)) : v;
  endfunction

  // Smallest power P with P^10 >= 10^k, so floor(10*log10(P)) >= k exactly;
  // saturates to all ones when no power of PWR_W bits reaches it.
  function automatic logic [PWR_W-1:0] db_threshold(input int k);
    logic [BIG_W-1:0] lim;
    logic [BIG_W-1:0] c;
    logic [BIG_W-1:0] c2;
    logic [BIG_W-1:0] c4;
    logic [BIG_W-1:0] c8;
    logic [BIG_W-1:0] c10;
    logic [PWR_W-1:0] t;
    logic [PWR_W-1:0] cand;
    lim = BIG_W'(1);
    for (int i = 0; i < k; i++) begin
      lim = lim * BIG_W'(10);
    end
    t = '0;
    for (int b = PWR_W - 1; b >= 0; b--) begin
      cand    = t;
      cand[b] = 1'b1;
      c       = BIG_W'(cand);
      c2      = c * c;
      c4      = c2 * c2;
      c8      = c4 * c4;
      c10     = c8 * c2;
      if (c10 < lim) begin
        t = cand;
      end
    end
    if (&t) begin
      return '1;
    end
    return t + PWR_W'(1);
  endfunction

endpackage

// File: src/lpsa_front.sv
// Front end: accepts bins, tracks bin, ring slot and frame count, builds jobs.
// Depends on lpsa_pkg.
module lpsa_front
  import lpsa_pkg::*;
#(
  parameter int FRAME_POINTS  = FRAME_POINTS_DEF,
  parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [IN_W-1:0]   in_re_i,
  input  logic [IN_W-1:0]   in_im_i,
  input  logic              push_ready_i,
  output logic              push_valid_o,
  output job_t              push_job_o
);

  localparam int BIN_W  = $clog2(FRAME_POINTS);
  localparam int SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int DIV_W  = SLOT_W + 1;

  logic [BIN_W-1:0]  bin_q, bin_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] seen_q, seen_d;
  logic              full_q, full_d;
  logic              last;
  logic              take;
  logic [BIN_W:0]    shifted;
  logic [BIN_W:0]    pos;

  assign take = in_valid_i && push_ready_i;
  assign last = (bin_q == BIN_W'(FRAME_POINTS - 1));

  // Shift by half a frame; the sum stays below twice the frame size.
  assign shifted = {1'b0, bin_q} + (BIN_W + 1)'(FRAME_POINTS / 2);
  assign pos = (shifted >= (BIN_W + 1)'(FRAME_POINTS)) ?
               shifted - (BIN_W + 1)'(FRAME_POINTS) : shifted;

  always_comb begin
    bin_d  = bin_q;
    slot_d = slot_q;
    seen_d = seen_q;
    full_d = full_q;
    if (take) begin
      if (last) begin
        bin_d  = '0;
        slot_d = (slot_q == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
        if (slot_q == SLOT_W'(AVERAGE_DEPTH - 1)) begin
          full_d = 1'b1;
        end
        if (seen_q != SLOT_W'(AVERAGE_DEPTH - 1)) begin
          seen_d = seen_q + SLOT_W'(1);
        end
      end else begin
        bin_d = bin_q + BIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q  <= '0;
      slot_q <= '0;
      seen_q <= '0;
      full_q <= 1'b0;
    end else begin
      bin_q  <= bin_d;
      slot_q <= slot_d;
      seen_q <= seen_d;
      full_q <= full_d;
    end
  end

  always_comb begin
    push_job_o           = '0;
    push_job_o.re        = in_re_i;
    push_job_o.im        = in_im_i;
    push_job_o.bin       = BIN_MAX_W'(bin_q);
    push_job_o.slot      = SLOT_MAX_W'(slot_q);
    push_job_o.disp      = POS_W'(pos);
    push_job_o.last      = last;
    push_job_o.had_prior = (slot_q != '0) || full_q;
    push_job_o.old_valid = full_q;
    push_job_o.divisor   = (SLOT_MAX_W + 1)'(DIV_W'(seen_q) + DIV_W'(1));
  end

  assign push_valid_o = in_valid_i;

endmodule

// File: src/lpsa_fifo.sv
// Two-entry job queue between front and back end.
// Depends on lpsa_pkg.
module lpsa_fifo
  import lpsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_job_o
);

  job_t       slots_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop_job_o    = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

// File: src/lpsa_back.sv
// Back end: power, decibel search, history and running-sum update, mean, output register.
// Depends on lpsa_pkg.
module lpsa_back
  import lpsa_pkg::*;
#(
  parameter int FRAME_POINTS  = FRAME_POINTS_DEF,
  parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [POS_W-1:0] out_pos_o,
  output logic [DB_W-1:0]  out_db_o,
  output logic             out_last_o
);

  localparam int BIN_W  = $clog2(FRAME_POINTS);
  localparam int SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int DIV_W  = SLOT_W + 1;
  localparam int SUM_W  = $clog2(AVERAGE_DEPTH * (DB_CODES - 1) + 1);
  localparam int HA_W   = $clog2(AVERAGE_DEPTH * FRAME_POINTS);
  localparam int CNT_W  = $clog2(SUM_W + 1);
  localparam int SH_W   = $clog2(2 * HALF_W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [PWR_W-1:0] th_tab [DB_CODES];

  for (genvar g = 0; g < DB_CODES; g++) begin : g_th
    localparam logic [PWR_W-1:0] TH = db_threshold(g);
    assign th_tab[g] = TH;
  end

  logic [DB_W-1:0]  hist_mem [AVERAGE_DEPTH * FRAME_POINTS];
  logic [SUM_W-1:0] sum_mem  [FRAME_POINTS];

  logic [2:0]        state_q, state_d;
  job_t              job_q;
  logic [IN_W-1:0]   mre_q, mim_q;
  logic [2:0]        step_q;
  logic [2*HALF_W-1:0] prod_q;
  logic [SH_W-1:0]   sh_q;
  logic [PWR_W-1:0]  acc_q;
  logic [2:0]        bit_q;
  logic [DB_W-1:0]   d_q;
  logic [DB_W-1:0]   hist_rd_q;
  logic [SUM_W-1:0]  sum_rd_q;
  logic [DIV_W-1:0]  rem_q;
  logic [SUM_W-1:0]  num_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [DB_W-1:0]   out_db_q;
  logic              out_last_q;

  logic              pop;
  logic [HA_W-1:0]   rd_addr, wr_addr;
  logic [HALF_W-1:0] ma, mb;
  logic [SH_W-1:0]   sh_now;
  logic [DB_W-1:0]   cand;
  logic [DB_W-1:0]   old_db;
  logic [SUM_W-1:0]  prior_sum;
  logic [SUM_W-1:0]  new_sum;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  divisor;
  logic              out_load;
  logic [DB_W-1:0]   mean;

  assign pop = (state_q == ST_IDLE) && job_valid_i;
  assign pop_o = pop;

  assign rd_addr = HA_W'(job_i.slot[SLOT_W-1:0]) * HA_W'(FRAME_POINTS)
                 + HA_W'(job_i.bin[BIN_W-1:0]);
  assign wr_addr = HA_W'(job_q.slot[SLOT_W-1:0]) * HA_W'(FRAME_POINTS)
                 + HA_W'(job_q.bin[BIN_W-1:0]);

  // Operand select for the six half-width partial products of re^2 + im^2.
  always_comb begin
    ma     = '0;
    mb     = '0;
    sh_now = '0;
    unique case (step_q)
      3'd0: begin ma = mre_q[HALF_W-1:0]; mb = mre_q[HALF_W-1:0]; sh_now = '0; end
      3'd1: begin ma = mre_q[HALF_W-1:0]; mb = mre_q[IN_W-1:HALF_W];
                  sh_now = SH_W'(HALF_W + 1); end
      3'd2: begin ma = mre_q[IN_W-1:HALF_W]; mb = mre_q[IN_W-1:HALF_W];
                  sh_now = SH_W'(2 * HALF_W); end
      3'd3: begin ma = mim_q[HALF_W-1:0]; mb = mim_q[HALF_W-1:0]; sh_now = '0; end
      3'd4: begin ma = mim_q[HALF_W-1:0]; mb = mim_q[IN_W-1:HALF_W];
                  sh_now = SH_W'(HALF_W + 1); end
      3'd5: begin ma = mim_q[IN_W-1:HALF_W]; mb = mim_q[IN_W-1:HALF_W];
                  sh_now = SH_W'(2 * HALF_W); end
      default: begin ma = '0; mb = '0; sh_now = '0; end
    endcase
  end

  assign cand      = d_q | (DB_W'(1) << bit_q);
  assign old_db    = job_q.old_valid ? hist_rd_q : '0;
  assign prior_sum = job_q.had_prior ? sum_rd_q : '0;
  assign new_sum   = prior_sum - SUM_W'(old_db) + SUM_W'(d_q);
  assign divisor   = job_q.divisor[DIV_W-1:0];
  assign trial     = {rem_q, num_q[SUM_W-1]};
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign mean      = (num_q > SUM_W'(DB_CODES - 1)) ? '1 : DB_W'(num_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop) state_d = ST_SQ;
      ST_SQ:   if (step_q == 3'd6) state_d = ST_SRCH;
      ST_SRCH: if (bit_q == 3'd0) state_d = ST_UPD;
      ST_UPD:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == CNT_W'(SUM_W - 1)) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers; control decides when they move.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q  <= job_i;
      mre_q  <= magnitude(job_i.re);
      mim_q  <= magnitude(job_i.im);
      step_q <= '0;
      acc_q  <= '0;
    end
    if (state_q == ST_SQ) begin
      step_q <= step_q + 3'd1;
      prod_q <= ma * mb;
      sh_q   <= sh_now;
      if (step_q != 3'd0) begin
        acc_q <= acc_q + (PWR_W'(prod_q) << sh_q);
      end
      bit_q <= 3'd7;
      d_q   <= '0;
    end
    if (state_q == ST_SRCH) begin
      bit_q <= bit_q - 3'd1;
      if (acc_q >= th_tab[cand]) begin
        d_q <= cand;
      end
    end
    if (state_q == ST_UPD) begin
      rem_q <= '0;
      num_q <= new_sum;
      cnt_q <= '0;
    end
    if (state_q == ST_DIV) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (trial >= {1'b0, divisor}) begin
        rem_q <= DIV_W'(trial - {1'b0, divisor});
        num_q <= {num_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= DIV_W'(trial);
        num_q <= {num_q[SUM_W-2:0], 1'b0};
      end
    end
    if (out_load) begin
      out_pos_q  <= job_q.disp;
      out_db_q   <= mean;
      out_last_q <= job_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      hist_rd_q <= hist_mem[rd_addr];
      sum_rd_q  <= sum_mem[job_i.bin[BIN_W-1:0]];
    end
    if (state_q == ST_UPD) begin
      hist_mem[wr_addr]                <= d_q;
      sum_mem[job_q.bin[BIN_W-1:0]]    <= new_sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pos_o   = out_pos_q;
  assign out_db_o    = out_db_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_upd_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |=> state_q == ST_DIV)
    else $error("update not followed by divide");
  a_db_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> d_q <= DB_W'(250))
    else $error("decibel value out of range");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> divisor != '0)
    else $error("zero divisor");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> state_q == ST_SQ)
    else $error("pop did not start squaring");
`endif

endmodule

// File: src/log_power_spectrum_averager_top.sv
// Log power spectrum averager: per-bin decibel value averaged over a ring of frames.
// The back end takes one item at a time and the next only once the last is loaded
// into its output register; its pace is set by the shared 21x21 multiplier, the
// eight-step threshold search and the bit-serial divider in the back end.
// Reset: asynchronous, active low; clears counters, queue and output valid. The history
// needs no clearing: entries are ignored until the ring has wrapped.
module log_power_spectrum_averager_top
  import lpsa_pkg::*;
#(
  parameter int FRAME_POINTS  = FRAME_POINTS_DEF,
  parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // bin_real[41:0], bin_imag[83:42], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // display_position[9:0], average_db[17:10], zero pad
  output logic        m_axis_tlast   // frame_end
);

  job_t             push_job, pop_job;
  logic             push_valid, push_ready;
  logic             pop_valid, pop;
  logic [POS_W-1:0] out_pos;
  logic [DB_W-1:0]  out_db;

  // Front: classify each bin and hand it to the queue.
  lpsa_front #(
    .FRAME_POINTS (FRAME_POINTS),
    .AVERAGE_DEPTH(AVERAGE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_re_i     (s_axis_tdata[IN_W-1:0]),
    .in_im_i     (s_axis_tdata[2*IN_W-1:IN_W]),
    .push_ready_i(push_ready),
    .push_valid_o(push_valid),
    .push_job_o  (push_job)
  );

  assign s_axis_tready = push_ready;

  // Queue: hold jobs while the back end is busy.
  lpsa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_job_o   (pop_job)
  );

  // Back: compute decibels, update history and sums, divide, register the result.
  lpsa_back #(
    .FRAME_POINTS (FRAME_POINTS),
    .AVERAGE_DEPTH(AVERAGE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_pos_o  (out_pos),
    .out_db_o   (out_db),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_db, out_pos};

endmodule

// File: tb/sv/tb_log_power_spectrum_averager_top.sv
// Testbench of log_power_spectrum_averager_top: directed bins, then random bins.
// Depends on lpsa_pkg and the averager RTL; predicts decibel means in its own code.
`timescale 1ns / 100ps

module tb_log_power_spectrum_averager_top;
  import lpsa_pkg::*;

  localparam int NPTS      = 1024;
  localparam int NDEPTH    = 10;
  localparam int NITEMS    = 1050;          // one full frame and the start of the next
  localparam int LIMIT     = 400_000;       // watchdog limit on the whole run, in clock cycles
  localparam int BW        = 900;           // holds power^10 and 10^256

  typedef struct {
    logic [9:0] pos;
    logic [7:0] db;
    logic       last;
  } spec_t;

  typedef struct {
    logic signed [41:0] re;
    logic signed [41:0] im;
    bit                 typed;  // expected dB typed in, first frame so mean equals dB
    logic [7:0]         db;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // bin_real[41:0], bin_imag[83:42], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // display_position[9:0], average_db[17:10], zero pad
  logic        m_axis_tlast;   // frame_end

  // Predictor state: its own copy of the history ring and counters.
  logic [7:0] hist_db [NDEPTH*NPTS];
  int         cur_bin;
  int         cur_slot;
  int         frames_done;
  logic [BW-1:0] pow10 [0:256];

  spec_t  pending_q[$];
  int     errors;
  int     n_sent;
  int     n_recv;
  int     n_max_db;
  longint cycles;
  bit     no_idle;

  log_power_spectrum_averager_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Largest d with 10^d <= P^10, P = re^2 + im^2; zero power maps to zero.
  function automatic logic [7:0] power_db(logic signed [41:0] re, logic signed [41:0] im);
    logic [41:0]   mr;
    logic [41:0]   mi;
    logic [BW-1:0] pw;
    logic [BW-1:0] p2;
    logic [BW-1:0] p10;
    int            d;
    mr  = re[41] ? (~re + 42'd1) : re;
    mi  = im[41] ? (~im + 42'd1) : im;
    pw  = BW'(mr) * BW'(mr) + BW'(mi) * BW'(mi);
    if (pw == '0) return 8'd0;
    p2  = pw * pw;
    p10 = p2 * p2;
    p10 = p10 * p10;
    p10 = p10 * p2;
    d   = 0;
    while (d < 255 && pow10[d+1] <= p10) d++;
    return 8'(d);
  endfunction

  // Store the bin's dB in the current slot and form the mean over the ring.
  function automatic spec_t average_bin(logic signed [41:0] re, logic signed [41:0] im);
    spec_t r;
    int    sum;
    int    div;
    int    mean;
    hist_db[cur_slot*NPTS + cur_bin] = power_db(re, im);
    sum = 0;
    for (int k = 0; k < NDEPTH; k++) sum += hist_db[k*NPTS + cur_bin];
    div  = (frames_done + 1 > NDEPTH) ? NDEPTH : frames_done + 1;
    mean = sum / div;
    if (mean > 255) mean = 255;
    r.pos  = 10'((cur_bin + NPTS/2) % NPTS);
    r.db   = 8'(mean);
    r.last = (cur_bin == NPTS - 1);
    if (r.last) begin
      cur_bin  = 0;
      cur_slot = (cur_slot + 1) % NDEPTH;
      if (frames_done < NDEPTH - 1) frames_done++;
    end else begin
      cur_bin++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH item %0d %s: got %0d expected %0d", n_recv, what, got, want);
    errors++;
  endtask

  // Random idle count; hold long stretches with no idling at all.
  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // Push one bin; it is taken at the first rising edge with tready high.
  task automatic push_bin(logic signed [41:0] re, logic signed [41:0] im);
    int gap;
    gap = idle_draw();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, im, re};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(average_bin(re, im));
    n_sent++;
  endtask

  // Random field: zero, an extreme, or a random value of random magnitude.
  function automatic logic signed [41:0] rand_field();
    logic signed [41:0] v;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return '0;
    if (kind == 1) return $urandom_range(0, 1) ? {1'b1, 41'd0} : {1'b0, {41{1'b1}}};
    v = 42'({$urandom, $urandom});
    return v >>> $urandom_range(0, 41);
  endfunction

  // Sink side: draw a stall per item, then accept.
  initial begin
    int st;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      st = idle_draw();
      @(negedge clk_i);
      if (st > 0) begin
        m_axis_tready <= 1'b0;
        repeat (st) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    spec_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result position", m_axis_tdata[9:0], -1);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[9:0] !== e.pos) report_mismatch("position", m_axis_tdata[9:0], e.pos);
        if (m_axis_tdata[17:10] !== e.db) report_mismatch("average", m_axis_tdata[17:10], e.db);
        if (m_axis_tdata[23:18] !== 6'd0) report_mismatch("pad", m_axis_tdata[23:18], 0);
        if (m_axis_tlast !== e.last) report_mismatch("last", m_axis_tlast, e.last);
        if (e.db >= 8'd249) n_max_db++;
      end
      n_recv++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
      $display("tb_log_power_spectrum_averager_top NOT OK");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    spec_t chk;
    int   wait_cnt;
    errors = 0; n_sent = 0; n_recv = 0; n_max_db = 0; cycles = 0; no_idle = 1'b0;
    cur_bin = 0; cur_slot = 0; frames_done = 0;
    foreach (hist_db[i]) hist_db[i] = 8'd0;
    pow10[0] = BW'(1);
    for (int i = 1; i <= 256; i++) pow10[i] = pow10[i-1] * BW'(10);

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; first frame, so the mean equals the bin's own dB.
    rows.push_back('{42'sd0, 42'sd0, 1'b1, 8'd0});                 // zero power
    rows.push_back('{42'sd1, 42'sd0, 1'b1, 8'd0});                 // unit power
    rows.push_back('{42'sd3, -42'sd1, 1'b1, 8'd10});               // power ten
    rows.push_back('{42'sd10, 42'sd0, 1'b1, 8'd20});               // power hundred
    rows.push_back('{{1'b1, 41'd0}, {1'b1, 41'd0}, 1'b1, 8'd249}); // most negative pair
    rows.push_back('{{1'b0, {41{1'b1}}}, {1'b0, {41{1'b1}}}, 1'b1, 8'd249});
    rows.push_back('{{1'b0, {41{1'b1}}}, {1'b1, 41'd0}, 1'b1, 8'd249});
    rows.push_back('{-42'sd1, -42'sd1, 1'b0, 8'd0});
    rows.push_back('{42'sd0, {1'b1, 41'd0}, 1'b0, 8'd0});
    rows.push_back('{42'sh2AA_AAAA_AAAA, 42'sh155_5555_5555, 1'b0, 8'd0});
    rows.push_back('{42'sh155_5555_5555, 42'sh2AA_AAAA_AAAA, 1'b0, 8'd0});
    foreach (rows[i]) begin
      r = rows[i];
      push_bin(r.re, r.im);
      if (r.typed) begin
        chk = pending_q[pending_q.size()-1];
        if (chk.db !== r.db) report_mismatch("directed dB", chk.db, r.db);
      end
    end

    // Random bins: past the end of the first frame into the second ring slot.
    while (n_sent < NITEMS) begin
      if ((n_sent % 300) == 0) no_idle = ($urandom_range(0, 3) == 0);
      push_bin(rand_field(), rand_field());
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    wait_cnt = 0;
    while (pending_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (100) @(posedge clk_i);

    $display("covered %0d bins over %0d frames, ring depth %0d; %0d results near full scale",
             n_sent, n_sent / NPTS, NDEPTH, n_max_db);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_log_power_spectrum_averager_top OK");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_q.size());
      $display("tb_log_power_spectrum_averager_top NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
src/lpsa_pkg.sv
src/lpsa_front.sv
src/lpsa_fifo.sv
src/lpsa_back.sv
src/log_power_spectrum_averager_top.sv
tb/sv/tb_log_power_spectrum_averager_top.sv
